// File: rtl/core/pfe_pkg.sv
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int DW        = 32;
    localparam int DIV_CNT_W = 6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } pfe_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_OPRD,
        S_DIV,
        S_OPWB,
        S_FIN,
        S_EMIT
    } pfe_state_t;

    typedef struct packed {
        logic capture;
        logic tok_step;
        logic note_under;
        logic op_read;
        logic op_calc;
        logic div_start;
        logic op_wb;
        logic fin_push;
        logic emit;
    } pfe_cmd_t;

    typedef struct packed {
        logic is_space;
        logic is_op;
        logic is_div;
        logic token_open;
        logic last;
        logic few_operands;
        logic divisor_zero;
        logic div_done;
        logic out_busy;
    } pfe_stat_t;

endpackage

// File: rtl/core/pfe_div.sv
`timescale 1ns / 1ps

module pfe_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [pfe_pkg::DW-1:0] dividend,
    input  logic [pfe_pkg::DW-1:0] divisor,
    output logic                 done,
    output logic [pfe_pkg::DW-1:0] quotient
);
    import pfe_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [DW-1:0]        q_reg, q_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [DW-1:0]        dsr_reg, dsr_next;
    logic [DW:0]          rem_shift;
    logic [DW:0]          diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        rem_shift = {rem_reg, q_reg[DW-1]};
        diff      = rem_shift - {1'b0, dsr_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[DW-1] ^ divisor[DW-1];
            q_next    = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
            dsr_next  = divisor[DW-1] ? (~divisor + DW'(1)) : divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (!diff[DW])
            begin
                rem_next = diff[DW-1:0];
                q_next   = {q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DW-1:0];
                q_next   = {q_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~q_reg + DW'(1)) : q_reg;

endmodule

// File: rtl/core/pfe_ctrl.sv
`timescale 1ns / 1ps

module pfe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  pfe_pkg::pfe_stat_t stat,
    output pfe_pkg::pfe_cmd_t  cmd
);
    import pfe_pkg::*;

    pfe_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_op && !stat.is_space && !stat.token_open)
                begin
                    if (stat.few_operands)
                    begin
                        cmd.note_under = 1'b1;
                        state_next     = stat.last ? S_FIN : S_IDLE;
                    end
                    else
                    begin
                        cmd.op_read = 1'b1;
                        state_next  = S_OPRD;
                    end
                end
                else
                begin
                    cmd.tok_step = 1'b1;
                    state_next   = stat.last ? S_FIN : S_IDLE;
                end
            end
            S_OPRD:
            begin
                if (stat.is_div && !stat.divisor_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.op_calc = 1'b1;
                    state_next  = S_OPWB;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_OPWB;
                end
            end
            S_OPWB:
            begin
                cmd.op_wb  = 1'b1;
                state_next = stat.last ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                cmd.fin_push = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/pfe_dp.sv
`timescale 1ns / 1ps

module pfe_dp #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             character,
    input  logic                   last,
    input  pfe_pkg::pfe_cmd_t      cmd,
    output pfe_pkg::pfe_stat_t     stat,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic [pfe_pkg::DW-1:0] value,
    output logic [1:0]             status
);
    import pfe_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DW-1:0] mem [STACK_DEPTH];

    logic [7:0]    char_reg;
    logic          last_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          token_open_reg, token_open_next;
    logic          stopped_reg, stopped_next;
    pfe_status_t   sticky_reg, sticky_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic [DW-1:0] tos_reg, tos_next;
    logic [DW-1:0] acc_reg, acc_next;
    logic [DW-1:0] res_reg, res_next;
    logic [DW-1:0] rd_reg;
    logic [DW-1:0] value_reg, value_next;
    pfe_status_t   status_reg, status_next;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [CW-1:0] count_m1;
    logic [CW-1:0] count_m2;
    logic          is_space;
    logic          is_op;
    logic          is_digit;
    logic          push_en;
    logic [DW-1:0] acc_base;
    logic          stop_base;
    logic [DW-1:0] prod;
    logic          div_done;
    logic [DW-1:0] div_q;

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign is_space = (char_reg == CH_SPACE);
    assign is_op    = (char_reg == CH_PLUS) || (char_reg == CH_MINUS) ||
                      (char_reg == CH_STAR) || (char_reg == CH_SLASH);
    assign is_digit = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign prod     = rd_reg * tos_reg;

    pfe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_reg),
        .divisor  (tos_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        stat.is_space     = is_space;
        stat.is_op        = is_op;
        stat.is_div       = (char_reg == CH_SLASH);
        stat.token_open   = token_open_reg;
        stat.last         = last_reg;
        stat.few_operands = (count_reg < CW'(2));
        stat.divisor_zero = (tos_reg == '0);
        stat.div_done     = div_done;
        stat.out_busy     = rsp_valid_reg && rsp_stall;
    end

    always_comb
    begin
        count_next      = count_reg;
        token_open_next = token_open_reg;
        stopped_next    = stopped_reg;
        sticky_next     = sticky_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        tos_next        = tos_reg;
        acc_next        = acc_reg;
        res_next        = res_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        mem_wa          = count_m1[AW-1:0];
        push_en         = 1'b0;
        acc_base        = token_open_reg ? acc_reg : '0;
        stop_base       = token_open_reg && stopped_reg;

        if (cmd.tok_step)
        begin
            if (is_space)
            begin
                if (token_open_reg)
                begin
                    push_en         = 1'b1;
                    token_open_next = 1'b0;
                end
            end
            else
            begin
                token_open_next = 1'b1;
                acc_next        = acc_base;
                stopped_next    = stop_base;
                if (!stop_base && is_digit)
                begin
                    acc_next = (acc_base << 3) + (acc_base << 1) +
                               {{(DW-4){1'b0}}, char_reg[3:0]};
                end
                else
                begin
                    stopped_next = 1'b1;
                end
            end
        end

        if (cmd.fin_push && token_open_reg)
        begin
            push_en         = 1'b1;
            token_open_next = 1'b0;
        end

        // push the accumulated token, spilling the old top into the array; a full stack flags overflow instead
        if (push_en)
        begin
            if (count_reg == CW'(STACK_DEPTH))
            begin
                if (sticky_next == ST_OK)
                begin
                    sticky_next = ST_OVER;
                end
            end
            else
            begin
                mem_we     = (count_reg != '0);
                tos_next   = acc_reg;
                count_next = count_reg + CW'(1);
            end
        end

        if (cmd.note_under && (sticky_next == ST_OK))
        begin
            sticky_next = ST_UNDER;
        end

        if (cmd.op_calc)
        begin
            case (char_reg)
                CH_PLUS:  res_next = rd_reg + tos_reg;
                CH_MINUS: res_next = rd_reg - tos_reg;
                CH_STAR:  res_next = prod;
                default:
                begin
                    res_next = '0;
                    if (sticky_next == ST_OK)
                    begin
                        sticky_next = ST_DIVZ;
                    end
                end
            endcase
        end

        if (div_done)
        begin
            res_next = div_q;
        end

        if (cmd.op_wb)
        begin
            tos_next   = res_reg;
            count_next = count_m1;
        end

        if (cmd.emit)
        begin
            rsp_valid_next  = 1'b1;
            value_next      = (count_reg != '0) ? tos_reg : '0;
            status_next     = ((count_reg == '0) && (sticky_reg == ST_OK)) ? ST_UNDER
                                                                          : sticky_reg;
            count_next      = '0;
            token_open_next = 1'b0;
            stopped_next    = 1'b0;
            sticky_next     = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            token_open_reg <= 1'b0;
            stopped_reg    <= 1'b0;
            sticky_reg     <= ST_OK;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            token_open_reg <= token_open_next;
            stopped_reg    <= stopped_next;
            sticky_reg     <= sticky_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            char_reg <= character;
            last_reg <= last;
        end
        tos_reg    <= tos_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= tos_reg;
        end
        if (cmd.op_read)
        begin
            rd_reg <= mem[count_m2[AW-1:0]];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count past depth");

    a_read_operands: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op_read |-> count_reg >= CW'(2))
        else $error("operand read with fewer than two entries");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (count_reg == '0) && (sticky_reg == ST_OK) && !token_open_reg)
        else $error("state not cleared after result");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(rsp_valid_reg && rsp_stall))
        else $error("result overwritten while stalled");

endmodule

// File: rtl/core/postfix_expression_evaluator_core.sv
`timescale 1ns / 1ps
// Channel  | Handshake             | Payload
// ---------+-----------------------+--------------------------------
// request  | req_valid / req_stall | character[7:0], last
// result   | rsp_valid / rsp_stall | value[31:0] signed, status[1:0]
//
// A / with a nonzero divisor runs through the 32-step shift-subtract divider;
// the last request also pushes any open token and forms the result.
// One request at a time; the single-port stack array reads the operand below the top of stack.
// Reset clears count, token and error state; stack contents need no clearing.
// A waiting result does not block new requests, only the next result.

module postfix_expression_evaluator_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [7:0]  character,
    input  logic        last,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] value,
    output logic [1:0]  status
);
    import pfe_pkg::*;

    pfe_cmd_t  cmd;
    pfe_stat_t stat;

    pfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    pfe_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .character (character),
        .last      (last),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .value     (value),
        .status    (status)
    );

endmodule
